// ===== hw/rtl/oaid_pkg.sv =====
// Package for the ordered array insert/delete block: request, response and cell command types,
// plus the mode and status codes. It depends on nothing else.
`timescale 1ns / 1ps

package oaid_pkg;

	localparam int WORD_W   = 32;
	localparam int POS_W    = 6;
	localparam int CNT_OUT_W = 7;
	localparam int CAP_W    = 7;

	// Request modes.
	localparam logic [2:0] MODE_APPEND    = 3'd0;
	localparam logic [2:0] MODE_INSERT    = 3'd1;
	localparam logic [2:0] MODE_DELETE    = 3'd2;
	localparam logic [2:0] MODE_OVERWRITE = 3'd3;
	localparam logic [2:0] MODE_READ      = 3'd4;

	// Response status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADIDX = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	// Cell update kinds broadcast along the row.
	localparam logic [2:0] CK_NONE   = 3'd0;
	localparam logic [2:0] CK_APPEND = 3'd1;
	localparam logic [2:0] CK_INSERT = 3'd2;
	localparam logic [2:0] CK_DELETE = 3'd3;
	localparam logic [2:0] CK_WRITE  = 3'd4;

	typedef struct packed {
		logic [2:0]              mode;
		logic [POS_W-1:0]        position;
		logic signed [WORD_W-1:0] word_in;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] word_out;
		logic [CNT_OUT_W-1:0]     element_count;
		logic                     is_empty;
		logic                     is_full;
	} rsp_t;

	typedef struct packed {
		logic [2:0]               kind;
		logic signed [WORD_W-1:0] word;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/oaid_cell.sv =====
// One slot of the shifting list: holds a word and takes it from the request, from the
// neighbor below (insert) or from the neighbor above (delete). Depends on oaid_pkg.
`timescale 1ns / 1ps

module oaid_cell #(
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  oaid_pkg::cell_cmd_t               cmd,
	input  logic [CW-1:0]                     pos,
	input  logic [CW-1:0]                     count,
	input  logic signed [oaid_pkg::WORD_W-1:0] lower_word,
	input  logic signed [oaid_pkg::WORD_W-1:0] upper_word,
	output logic signed [oaid_pkg::WORD_W-1:0] word
);

	localparam logic [CW:0] MY_IDX = (CW+1)'(IDX);

	logic signed [oaid_pkg::WORD_W-1:0] word_q;
	logic signed [oaid_pkg::WORD_W-1:0] next_word;
	logic [CW:0] pos_x;
	logic [CW:0] cnt_x;

	assign pos_x = {1'b0, pos};
	assign cnt_x = {1'b0, count};

	always_comb begin
		next_word = word_q;
		unique case (cmd.kind)
			oaid_pkg::CK_APPEND: begin
				if (MY_IDX == cnt_x) next_word = cmd.word;
			end
			oaid_pkg::CK_INSERT: begin
				if (MY_IDX == pos_x) next_word = cmd.word;
				else if (MY_IDX > pos_x && MY_IDX <= cnt_x) next_word = lower_word;
			end
			oaid_pkg::CK_DELETE: begin
				if (MY_IDX >= pos_x && (MY_IDX + 1'b1) < cnt_x) next_word = upper_word;
			end
			oaid_pkg::CK_WRITE: begin
				if (MY_IDX == pos_x) next_word = cmd.word;
			end
			default: next_word = word_q;
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= next_word;
	end

	assign word = word_q;

endmodule

// ===== hw/rtl/ordered_array_insert_delete_top.sv =====
// Top level of the ordered array insert/delete block: request decode, count and capacity
// registers, the row of oaid_cell slots and the response register. Depends on oaid_pkg, oaid_cell.
`timescale 1ns / 1ps

// A request beat is taken at every rising edge where start is high and busy is low; busy never
// rises, so one request can be issued in every cycle. Each request yields exactly one response
// beat, shown on rsp with done high for one cycle, in the cycle after the request was taken. The
// receiver cannot stall: it must capture rsp in the cycle where done is high. The list lives in a
// row of DEPTH cells; on insert or delete all cells from the position to the end of the list
// move in the same cycle, so no request takes longer for its position. Reads select the
// addressed cell through a wide OR of per-cell hits. The capacity register is written with
// cfg_wr_en and cfg_wr_data and should only be changed while no response is pending.
module ordered_array_insert_delete_top #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  oaid_pkg::req_t                   req,
	output logic                             done,
	output oaid_pkg::rsp_t                   rsp,
	input  logic                             cfg_wr_en,
	input  logic [oaid_pkg::CAP_W-1:0]       cfg_wr_data
);

	// Width of the element count, which must hold DEPTH itself.
	localparam int CW = $clog2(DEPTH + 1);
	// Common width for comparing count, position and capacity.
	localparam int LW = (CW > oaid_pkg::CAP_W) ? CW : oaid_pkg::CAP_W;
	localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

	logic [oaid_pkg::CAP_W-1:0] cap_q;
	logic [CW-1:0]              count_q;
	oaid_pkg::rsp_t             rsp_q;
	logic                       done_q;

	logic [LW-1:0] cap_raw;
	logic [LW-1:0] cap_eff;
	logic [LW-1:0] cnt_l;
	logic [LW-1:0] pos_l;
	logic [LW-1:0] new_cnt_l;
	logic          full;
	logic          accept;

	logic [1:0]                          status;
	logic [CW-1:0]                       new_count;
	logic signed [oaid_pkg::WORD_W-1:0]  rd_word;
	logic signed [oaid_pkg::WORD_W-1:0]  hit_word;
	oaid_pkg::cell_cmd_t                 cmd;
	logic [CW-1:0]                       cell_pos;

	logic signed [oaid_pkg::WORD_W-1:0] cell_word [DEPTH];

	assign accept  = start & ~busy;
	assign busy    = 1'b0;

	// Capacity of zero acts as one, anything above the built depth acts as DEPTH.
	assign cap_raw = LW'(cap_q);
	always_comb begin
		if (cap_raw == '0) cap_eff = LW'(1);
		else if (cap_raw > DEPTH_L) cap_eff = DEPTH_L;
		else cap_eff = cap_raw;
	end

	assign cnt_l = LW'(count_q);
	assign pos_l = LW'(req.position);
	assign full  = cnt_l >= cap_eff;

	// Positions beyond the row never match a cell; clamp keeps the broadcast in range.
	assign cell_pos = (pos_l > DEPTH_L) ? CW'(DEPTH) : CW'(pos_l);

	// Read select: each cell contributes its word only when its index matches the position.
	always_comb begin
		hit_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (pos_l == LW'(i)) hit_word = hit_word | cell_word[i];
		end
	end

	// Request decode: status, next count, read data and the command for the cell row.
	always_comb begin
		status    = oaid_pkg::ST_OK;
		new_count = count_q;
		rd_word   = '1;
		cmd.kind  = oaid_pkg::CK_NONE;
		cmd.word  = req.word_in;
		unique case (req.mode)
			oaid_pkg::MODE_APPEND: begin
				if (full) begin
					status = oaid_pkg::ST_FULL;
				end else begin
					cmd.kind  = oaid_pkg::CK_APPEND;
					new_count = count_q + 1'b1;
				end
			end
			oaid_pkg::MODE_INSERT: begin
				if (full) begin
					status = oaid_pkg::ST_FULL;
				end else if (pos_l > cnt_l) begin
					status = oaid_pkg::ST_BADIDX;
				end else begin
					cmd.kind  = oaid_pkg::CK_INSERT;
					new_count = count_q + 1'b1;
				end
			end
			oaid_pkg::MODE_DELETE: begin
				if (count_q == '0) begin
					status = oaid_pkg::ST_EMPTY;
				end else if (pos_l >= cnt_l) begin
					status = oaid_pkg::ST_BADIDX;
				end else begin
					cmd.kind  = oaid_pkg::CK_DELETE;
					new_count = count_q - 1'b1;
				end
			end
			oaid_pkg::MODE_OVERWRITE: begin
				if (pos_l >= cnt_l) status = oaid_pkg::ST_BADIDX;
				else cmd.kind = oaid_pkg::CK_WRITE;
			end
			oaid_pkg::MODE_READ: begin
				if (pos_l >= cnt_l) status = oaid_pkg::ST_BADIDX;
				else rd_word = hit_word;
			end
			default: status = oaid_pkg::ST_BADIDX;
		endcase
		// Nothing moves unless the request beat is actually taken.
		if (!accept) cmd.kind = oaid_pkg::CK_NONE;
	end

	assign new_cnt_l = LW'(new_count);

	// The row of slots: cell i sees cell i-1 below and cell i+1 above.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [oaid_pkg::WORD_W-1:0] lower;
		logic signed [oaid_pkg::WORD_W-1:0] upper;
		if (g == 0) begin : g_lo_edge
			assign lower = '0;
		end else begin : g_lo
			assign lower = cell_word[g-1];
		end
		if (g == DEPTH - 1) begin : g_hi_edge
			assign upper = '0;
		end else begin : g_hi
			assign upper = cell_word[g+1];
		end
		oaid_cell #(
			.CW  (CW),
			.IDX (g)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.pos        (cell_pos),
			.count      (count_q),
			.lower_word (lower),
			.upper_word (upper),
			.word       (cell_word[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= oaid_pkg::CAP_W'(64);
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) cap_q <= cfg_wr_data;
			if (accept) count_q <= new_count;
			done_q <= accept;
		end
	end

	// Response payload needs no reset; done qualifies it.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status        <= status;
			rsp_q.word_out      <= rd_word;
			rsp_q.element_count <= oaid_pkg::CNT_OUT_W'(new_count);
			rsp_q.is_empty      <= (new_count == '0);
			rsp_q.is_full       <= (new_cnt_l >= cap_eff);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
